// ----- design/bole_pkg.sv -----
// shared types, codes and constants of the bounded ordered list engine
`default_nettype none

package bole_pkg;

	localparam int BOLE_CAPACITY = 16;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_REPLACE = 2'd2,
		OP_DUMP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} res_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SH_RD,
		S_SH_WR,
		S_SCAN_RD,
		S_SCAN_EV,
		S_DEL_RD,
		S_DEL_WR,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_PREV,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_VAL,
		WR_SHIFT,
		WR_NEW
	} wr_sel_t;

	typedef struct packed {
		logic        load;
		logic        clr;
		logic        idx_set_len;
		logic        idx_inc;
		logic        idx_dec;
		logic        rd_en;
		rd_sel_t     rd_sel;
		logic        wr_en;
		wr_sel_t     wr_sel;
		logic        cnt_inc;
		logic        pos_from_idx;
		logic        len_inc;
		logic        len_dec;
		logic        out_load_resp;
		logic        out_load_dump;
		res_status_t st;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic bad_pos;
		logic empty;
		logic match;
		logic at_ins_pos;
		logic idx_last;
		logic cnt_zero;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ----- design/bole_ctrl.sv -----
// controller state machine of the bounded ordered list engine
`default_nettype none

module bole_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire bole_pkg::stat_t stat,
	output bole_pkg::cmd_t      cmd,
	output logic                ready
);
	import bole_pkg::*;

	state_t      state_q, state_d;
	res_status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.op == OP_INSERT) begin
					if (stat.full) begin
						state_d = S_RESP;
						st_d    = ST_FULL;
					end else if (stat.bad_pos) begin
						state_d = S_RESP;
						st_d    = ST_BADPOS;
					end else begin
						state_d = S_SH_RD;
					end
				end else if (stat.empty) begin
					state_d = S_RESP;
					st_d    = ST_EMPTY;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SH_RD: begin
				if (stat.at_ins_pos) begin
					state_d = S_RESP;
					st_d    = ST_OK;
				end else begin
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: state_d = S_SH_RD;
			S_SCAN_RD: state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				case (stat.op)
					OP_DELETE: begin
						if (stat.match) begin
							state_d = S_DEL_RD;
						end else if (stat.idx_last) begin
							state_d = S_RESP;
							st_d    = ST_NOTFOUND;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					OP_REPLACE: begin
						if (stat.idx_last) begin
							state_d = S_RESP;
							st_d    = (stat.match || !stat.cnt_zero) ? ST_OK : ST_NOTFOUND;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					OP_DUMP: begin
						if (stat.out_free) state_d = stat.idx_last ? S_IDLE : S_SCAN_RD;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DEL_RD: begin
				if (stat.idx_last) begin
					state_d = S_RESP;
					st_d    = ST_OK;
				end else begin
					state_d = S_DEL_WR;
				end
			end
			S_DEL_WR: state_d = S_DEL_RD;
			S_RESP: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_IDX;
		cmd.wr_sel = WR_VAL;
		cmd.st     = st_q;
		ready      = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: cmd.load = cmd_valid;
			S_DECIDE: begin
				cmd.clr         = 1'b1;
				cmd.idx_set_len = (stat.op == OP_INSERT);
			end
			S_SH_RD: begin
				if (stat.at_ins_pos) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_VAL;
					cmd.len_inc = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
				end
			end
			S_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_dec = 1'b1;
			end
			S_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
			end
			S_SCAN_EV: begin
				case (stat.op)
					OP_DELETE: begin
						if (stat.match) cmd.pos_from_idx = 1'b1;
						else cmd.idx_inc = !stat.idx_last;
					end
					OP_REPLACE: begin
						if (stat.match) begin
							cmd.wr_en        = 1'b1;
							cmd.wr_sel       = WR_NEW;
							cmd.cnt_inc      = 1'b1;
							cmd.pos_from_idx = stat.cnt_zero;
						end
						cmd.idx_inc = !stat.idx_last;
					end
					OP_DUMP: begin
						if (stat.out_free) begin
							cmd.out_load_dump = 1'b1;
							cmd.idx_inc       = !stat.idx_last;
						end
					end
					default: ;
				endcase
			end
			S_DEL_RD: begin
				if (stat.idx_last) begin
					cmd.len_dec = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_inc = 1'b1;
			end
			S_RESP: cmd.out_load_resp = stat.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/bole_dp.sv -----
// datapath of the bounded ordered list engine: list memory, counters, result register
`default_nettype none

module bole_dp #(
	parameter int CAPACITY = bole_pkg::BOLE_CAPACITY
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bole_pkg::cmd_t     cmd,
	output bole_pkg::stat_t         stat,
	input  wire logic [1:0]         opcode,
	input  wire logic [6:0]         position,
	input  wire logic signed [31:0] value,
	input  wire logic signed [31:0] new_value,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [2:0]              status,
	output logic [6:0]              out_position,
	output logic signed [31:0]      out_value,
	output logic [6:0]              match_count,
	output logic                    last
);
	import bole_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);

	op_t           op_q;
	logic [6:0]    pos_q;
	logic [31:0]   val_q, nval_q;
	logic [LW-1:0] len_q, cnt_q;
	logic [IW-1:0] idx_q, rd_addr;
	logic [6:0]    res_pos_q;
	logic [31:0]   rdata_q, wdata;
	logic [31:0]   mem [CAPACITY];
	logic [LW-1:0] idx_p1;
	logic          out_valid_q;
	logic          out_free;

	assign idx_p1   = LW'(idx_q) + LW'(1);
	assign out_free = !out_valid_q || !res_stall;

	always_comb begin
		stat.op         = op_q;
		stat.full       = (len_q == LW'(CAPACITY));
		stat.bad_pos    = (pos_q == 7'd0) || (pos_q > (7'(len_q) + 7'd1));
		stat.empty      = (len_q == '0);
		stat.match      = (rdata_q == val_q);
		stat.at_ins_pos = (7'(idx_q) == (pos_q - 7'd1));
		stat.idx_last   = (idx_p1 == len_q);
		stat.cnt_zero   = (cnt_q == '0);
		stat.out_free   = out_free;
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_PREV: rd_addr = idx_q - IW'(1);
			RD_NEXT: rd_addr = idx_q + IW'(1);
			default: rd_addr = idx_q;
		endcase
		case (cmd.wr_sel)
			WR_SHIFT: wdata = rdata_q;
			WR_NEW:   wdata = nval_q;
			default:  wdata = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[idx_q] <= wdata;
		if (cmd.rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(opcode);
			pos_q  <= position;
			val_q  <= value;
			nval_q <= new_value;
		end
		if (cmd.pos_from_idx) res_pos_q <= 7'(idx_p1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.len_inc) len_q <= len_q + LW'(1);
			else if (cmd.len_dec) len_q <= len_q - LW'(1);
			if (cmd.clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + LW'(1);
			if (cmd.idx_set_len) idx_q <= IW'(len_q);
			else if (cmd.clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + IW'(1);
			else if (cmd.idx_dec) idx_q <= idx_q - IW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_resp || cmd.out_load_dump) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_resp) begin
			status <= cmd.st;
			if (cmd.st != ST_OK) out_position <= 7'd0;
			else if (op_q == OP_INSERT) out_position <= pos_q;
			else out_position <= res_pos_q;
			out_value   <= (op_q == OP_DUMP) ? 32'sd0 : $signed(val_q);
			match_count <= (op_q == OP_REPLACE) ? 7'(cnt_q) : 7'(len_q);
			last        <= 1'b1;
		end else if (cmd.out_load_dump) begin
			status       <= ST_OK;
			out_position <= 7'(idx_p1);
			out_value    <= $signed(rdata_q);
			match_count  <= 7'(len_q);
			last         <= stat.idx_last;
		end
	end

	assign res_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- design/bounded_ordered_list_engine.sv -----
// insert shifts from the tail to its position; delete scans and shifts up; replace and
// dump scan the list, dump waiting out stalls; errors and empty lists skip to the result
// one command at a time; the next is taken the cycle after its last result is loaded
// each shift step is a read then a write on the list memory
// the result register lets the next command be taken while a result waits
// reset clears the list length and control; the store is never read before written
`default_nettype none

module bounded_ordered_list_engine #(
	parameter int CAPACITY = bole_pkg::BOLE_CAPACITY
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic [6:0]         position,
	input  wire logic signed [31:0] value,
	input  wire logic signed [31:0] new_value,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [2:0]              status,
	output logic [6:0]              out_position,
	output logic signed [31:0]      out_value,
	output logic [6:0]              match_count,
	output logic                    last
);
	import bole_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  ready;

	assign cmd_stall = !ready;

	bole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.stat      (stat),
		.cmd       (cmd),
		.ready     (ready)
	);

	bole_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.position     (position),
		.value        (value),
		.new_value    (new_value),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.out_position (out_position),
		.out_value    (out_value),
		.match_count  (match_count),
		.last         (last)
	);

endmodule

`default_nettype wire

// ----- sim/bounded_ordered_list_engine_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the bounded ordered list engine with a shadow list scoreboard
module bounded_ordered_list_engine_tb;
	import bole_pkg::*;

	localparam int CAP = BOLE_CAPACITY;

	typedef struct {
		res_status_t        st;
		logic [6:0]         pos;
		logic signed [31:0] val;
		logic [6:0]         cnt;
		logic               lst;
	} list_result_t;

	class list_scoreboard;
		logic signed [31:0] elems[CAP];
		int                 length;
		list_result_t       expected_results[$];
		int                 errors;
		int                 commands;
		int                 results;
		int                 by_status[5];

		function new();
			length = 0;
			errors = 0;
			commands = 0;
			results = 0;
			foreach (by_status[i]) by_status[i] = 0;
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void add_result(res_status_t st, int pos, logic signed [31:0] val, int cnt,
				bit lst);
			list_result_t r;
			r.st = st;
			r.pos = pos[6:0];
			r.val = val;
			r.cnt = cnt[6:0];
			r.lst = lst;
			by_status[int'(st)]++;
			expected_results.push_back(r);
		endfunction

		function void note_command(op_t op, logic [6:0] pos, logic signed [31:0] val,
				logic signed [31:0] nval);
			int n;
			int k;
			int hits;
			int first_hit;
			n = length;
			commands++;
			case (op)
			OP_INSERT: begin
				if (n >= CAP) begin
					add_result(ST_FULL, 0, val, n, 1'b1);
				end else if (int'(pos) < 1 || int'(pos) > n + 1) begin
					add_result(ST_BADPOS, 0, val, n, 1'b1);
				end else begin
					for (k = n; k >= int'(pos); k--) elems[k] = elems[k - 1];
					elems[int'(pos) - 1] = val;
					length = n + 1;
					add_result(ST_OK, int'(pos), val, n + 1, 1'b1);
				end
			end
			OP_DELETE: begin
				if (n == 0) begin
					add_result(ST_EMPTY, 0, val, 0, 1'b1);
				end else begin
					k = 0;
					while (k < n && elems[k] !== val) k++;
					if (k == n) begin
						add_result(ST_NOTFOUND, 0, val, n, 1'b1);
					end else begin
						first_hit = k;
						for (; k + 1 < n; k++) elems[k] = elems[k + 1];
						length = n - 1;
						add_result(ST_OK, first_hit + 1, val, n - 1, 1'b1);
					end
				end
			end
			OP_REPLACE: begin
				if (n == 0) begin
					add_result(ST_EMPTY, 0, val, 0, 1'b1);
				end else begin
					hits = 0;
					first_hit = 0;
					for (k = 0; k < n; k++) begin
						if (elems[k] === val) begin
							if (hits == 0) first_hit = k + 1;
							elems[k] = nval;
							hits++;
						end
					end
					add_result(hits != 0 ? ST_OK : ST_NOTFOUND, first_hit, val, hits, 1'b1);
				end
			end
			default: begin
				if (n == 0) begin
					add_result(ST_EMPTY, 0, 32'sd0, 0, 1'b1);
				end else begin
					for (k = 0; k < n; k++) add_result(ST_OK, k + 1, elems[k], n, k + 1 == n);
				end
			end
			endcase
		endfunction

		task check_result(logic [2:0] st, logic [6:0] pos, logic signed [31:0] val,
				logic [6:0] cnt, logic lst);
			list_result_t e;
			results++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d position %0d value %0d",
					st, pos, val));
				return;
			end
			e = expected_results.pop_front();
			if (st !== e.st)
				report_mismatch($sformatf("status got %0d want %0d", st, e.st));
			if (pos !== e.pos)
				report_mismatch($sformatf("out_position got %0d want %0d", pos, e.pos));
			if (val !== e.val)
				report_mismatch($sformatf("out_value got %0d want %0d", val, e.val));
			if (cnt !== e.cnt)
				report_mismatch($sformatf("match_count got %0d want %0d", cnt, e.cnt));
			if (lst !== e.lst)
				report_mismatch($sformatf("last got %0b want %0b", lst, e.lst));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [1:0]         opcode;
	logic [6:0]         position;
	logic signed [31:0] value;
	logic signed [31:0] new_value;
	logic               res_valid;
	logic               res_stall;
	logic [2:0]         status;
	logic [6:0]         out_position;
	logic signed [31:0] out_value;
	logic [6:0]         match_count;
	logic               last;

	list_scoreboard     sb = new();
	bit                 steady = 1'b0;
	logic signed [31:0] value_pool[6] = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff,
		32'sh80000000, 32'sd42};

	bounded_ordered_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode(opcode),
		.position(position),
		.value(value),
		.new_value(new_value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.out_position(out_position),
		.out_value(out_value),
		.match_count(match_count),
		.last(last)
	);

	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return value_pool[$urandom_range(0, 5)];
		if (r < 70 && sb.length > 0) return sb.elems[$urandom_range(0, sb.length - 1)];
		return $urandom;
	endfunction

	task automatic send_command(op_t op, logic [6:0] pos, logic signed [31:0] val,
			logic signed [31:0] nval);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= op;
		position <= pos;
		value <= val;
		new_value <= nval;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(op, pos, val, nval);
	endtask

	// fill leans on inserts, drain on deletes, mixed spreads the operations
	task automatic random_phase(int items, int mode);
		int i;
		int r;
		int pick;
		op_t op;
		logic [6:0] pos;
		for (i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			case (mode)
			0: op = r < 70 ? OP_INSERT : r < 80 ? OP_DELETE : r < 90 ? OP_REPLACE : OP_DUMP;
			1: op = r < 10 ? OP_INSERT : r < 75 ? OP_DELETE : r < 85 ? OP_REPLACE : OP_DUMP;
			default: op = r < 35 ? OP_INSERT : r < 60 ? OP_DELETE : r < 85 ? OP_REPLACE : OP_DUMP;
			endcase
			pick = $urandom_range(0, 99);
			if (op != OP_INSERT || pick >= 95)
				pos = 7'($urandom_range(0, 127));
			else if (pick < 88)
				pos = 7'($urandom_range(1, sb.length + 1));
			else
				pos = 7'd0;
			send_command(op, pos, pick_value(), pick_value());
		end
	endtask

	initial begin
		int hold;
		hold = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				sb.check_result(status, out_position, out_value, match_count, last);
			res_stall <= hold > 0;
			if (hold > 0)
				hold--;
			else if ($urandom_range(0, 3) == 0)
				hold = idle_len();
		end
	end

	initial begin
		int sent;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		opcode <= OP_INSERT;
		position <= 7'd0;
		value <= 32'sd0;
		new_value <= 32'sd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(OP_DUMP, 7'd0, 32'sd3, 32'sd4);
		send_command(OP_DELETE, 7'd1, 32'sd7, 32'sd0);
		send_command(OP_REPLACE, 7'd1, 32'sd7, 32'sd8);
		send_command(OP_INSERT, 7'd0, 32'sd1, 32'sd0);
		send_command(OP_INSERT, 7'd2, 32'sd1, 32'sd0);
		send_command(OP_INSERT, 7'd127, 32'sd1, -32'sd1);
		send_command(OP_INSERT, 7'd1, 32'sh7fffffff, 32'sd0);
		send_command(OP_INSERT, 7'd2, 32'sh80000000, 32'sd0);
		send_command(OP_INSERT, 7'd1, 32'sd0, 32'sd0);
		send_command(OP_INSERT, 7'd4, -32'sd1, 32'sd0);
		send_command(OP_INSERT, 7'd2, 32'sd5, 32'sd0);
		send_command(OP_DUMP, 7'd0, 32'sd0, 32'sd0);
		send_command(OP_DELETE, 7'd0, 32'sd123, 32'sd0);
		// head and tail removal
		send_command(OP_DELETE, 7'd0, 32'sd0, 32'sd0);
		send_command(OP_DELETE, 7'd0, -32'sd1, 32'sd0);
		send_command(OP_REPLACE, 7'd0, 32'sh80000000, 32'sd5);
		send_command(OP_REPLACE, 7'd0, 32'sd5, 32'sd9);
		send_command(OP_REPLACE, 7'd0, 32'sd77, 32'sd1);
		send_command(OP_INSERT, 7'd5, 32'sd6, 32'sd0);
		send_command(OP_DUMP, 7'd127, -32'sd1, -32'sd1);

		sent = 20;
		while (sent < 380) begin
			steady = $urandom_range(0, 4) == 0;
			random_phase(30, 0);
			random_phase(20, 2);
			random_phase(22, 1);
			sent += 72;
		end
		steady = 1'b0;
		cmd_valid <= 1'b0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d commands and checked %0d result transfers", sb.commands,
			sb.results);
		$display("outcomes seen: ok %0d, full %0d, bad position %0d, not found %0d, empty %0d",
			sb.by_status[0], sb.by_status[1], sb.by_status[2], sb.by_status[3],
			sb.by_status[4]);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("timeout with %0d results outstanding", sb.expected_results.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- bounded_ordered_list_engine.f -----
design/bole_pkg.sv
design/bole_ctrl.sv
design/bole_dp.sv
design/bounded_ordered_list_engine.sv
sim/bounded_ordered_list_engine_tb.sv
